// File: sv/vsb_pkg.sv
// ----------------------------------------------------------------------------
// vsb_pkg
// Shared types and constants of the vertex skinning blend core.
// ----------------------------------------------------------------------------
package vsb_pkg;

    // item kinds on the input channel
    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_SKIN = 1'b1
    } t_action;

    // fixed geometry of one bone matrix
    localparam int NUM_ROWS       = 3;
    localparam int NUM_COLS       = 4;
    localparam int ELEMS_PER_BONE = NUM_ROWS * NUM_COLS;
    localparam int MAX_SLOTS      = 3;

    // field widths
    localparam int WORD_W      = 32;
    localparam int BONE_W      = 7;
    localparam int SLOT_W      = 4;
    localparam int WEIGHT_W    = 17;
    localparam int WEIGHT_FRAC = 16;

    // datapath widths
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int TERM_W     = 44;
    localparam int TERM_SPLIT = 22;
    localparam int ACC_W      = 64;

    // register stages from input beat to output register
    localparam int PIPE_DEPTH = 8;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [BONE_W-1:0] t_bone;
    typedef logic        [WEIGHT_W-1:0] t_weight;

endpackage

// File: sv/vsb_bone_store.sv
// ----------------------------------------------------------------------------
// vsb_bone_store
// Bone matrix store: one bank per matrix element and per bone slot, so all
// elements of all bones of a vertex are read in the same cycle. Loads write the
// element into every slot copy. Read data is registered.
// ----------------------------------------------------------------------------
module vsb_bone_store #(
    parameter int NUM_BONES = 64,
    parameter int NUM_SLOTS = 3,
    parameter int BONE_AW   = 6
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic                   i_wr_en,
    input  logic [BONE_AW-1:0]     i_wr_addr,
    input  logic [vsb_pkg::SLOT_W-1:0] i_wr_slot,
    input  vsb_pkg::t_word         i_wr_data,
    input  logic [BONE_AW-1:0]     i_rd_addr [vsb_pkg::MAX_SLOTS],
    output vsb_pkg::t_word         o_elem [vsb_pkg::MAX_SLOTS][vsb_pkg::ELEMS_PER_BONE]
);
    import vsb_pkg::*;

    for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_slot
        if (k < NUM_SLOTS) begin : g_used
            for (genvar e = 0; e < ELEMS_PER_BONE; e++) begin : g_bank
                t_word r_mem [NUM_BONES];
                t_word r_q;

                // write port, shared by all slot copies
                always_ff @(posedge i_clk) begin
                    if (i_wr_en && (i_wr_slot == SLOT_W'(e))) begin
                        r_mem[i_wr_addr] <= i_wr_data;
                    end
                end

                // registered read port
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_q <= r_mem[i_rd_addr[k]];
                    end
                end

                assign o_elem[k][e] = r_q;
            end
        end else begin : g_unused
            for (genvar e = 0; e < ELEMS_PER_BONE; e++) begin : g_zero
                assign o_elem[k][e] = '0;
            end
        end
    end

endmodule

// File: sv/vsb_row_xform.sv
// ----------------------------------------------------------------------------
// vsb_row_xform
// Affine transform of the rest position by one bone matrix, three rows in
// parallel: products, partial sums, floor to the fixed point and saturation
// to the term width. Three register stages.
// ----------------------------------------------------------------------------
module vsb_row_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_use,
    input  vsb_pkg::t_word i_elem [vsb_pkg::ELEMS_PER_BONE],
    input  vsb_pkg::t_word i_pos  [vsb_pkg::NUM_ROWS],
    output vsb_pkg::t_term o_term [vsb_pkg::NUM_ROWS]
);
    import vsb_pkg::*;

    logic signed [PROD_W-1:0] r_prod [NUM_ROWS][NUM_ROWS];
    logic signed [PROD_W-1:0] r_ofs  [NUM_ROWS];
    logic signed [PROD_W-1:0] n_prod [NUM_ROWS][NUM_ROWS];
    logic signed [PROD_W-1:0] n_ofs  [NUM_ROWS];
    logic signed [SUM_W-1:0]  r_sa   [NUM_ROWS];
    logic signed [SUM_W-1:0]  r_sb   [NUM_ROWS];
    t_term                    r_term [NUM_ROWS];
    t_term                    n_term [NUM_ROWS];
    t_word                    w_elem [ELEMS_PER_BONE];

    // unused bone reads as an all-zero matrix
    always_comb begin
        for (int e = 0; e < ELEMS_PER_BONE; e++) begin
            w_elem[e] = i_use ? i_elem[e] : '0;
        end
    end

    // stage 1: element times coordinate, translation scaled up
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                n_prod[r][c] = w_elem[r*NUM_COLS + c] * i_pos[c];
            end
            n_ofs[r] = PROD_W'(w_elem[r*NUM_COLS + NUM_ROWS]) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_ofs  <= n_ofs;
        end
    end

    // stage 2: pairwise sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_sa[r] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1]);
                r_sb[r] <= SUM_W'(r_prod[r][2]) + SUM_W'(r_ofs[r]);
            end
        end
    end

    // stage 3: final sum, floor shift, saturate
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] sh;
        logic                    ovf;
        for (int r = 0; r < NUM_ROWS; r++) begin
            s   = r_sa[r] + r_sb[r];
            sh  = s >>> FRAC_BITS;
            ovf = !((&sh[SUM_W-1:TERM_W-1]) || !(|sh[SUM_W-1:TERM_W-1]));
            if (ovf) begin
                n_term[r] = sh[SUM_W-1] ? {1'b1, {(TERM_W-1){1'b0}}}
                                        : {1'b0, {(TERM_W-1){1'b1}}};
            end else begin
                n_term[r] = sh[TERM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
        end
    end

    assign o_term = r_term;

endmodule

// File: sv/vsb_blend.sv
// ----------------------------------------------------------------------------
// vsb_blend
// Weighting of the per-bone terms, sum over bones, floor by the weight
// fraction and saturation to 32 bits. Weights arrive three stages ahead of
// the terms and are delayed here. Four register stages.
// ----------------------------------------------------------------------------
module vsb_blend (
    input  logic             i_clk,
    input  logic             i_en,
    input  vsb_pkg::t_weight i_weight [vsb_pkg::MAX_SLOTS],
    input  vsb_pkg::t_term   i_term   [vsb_pkg::MAX_SLOTS][vsb_pkg::NUM_ROWS],
    output vsb_pkg::t_word   o_pos    [vsb_pkg::NUM_ROWS]
);
    import vsb_pkg::*;

    localparam int PL_W = TERM_SPLIT + WEIGHT_W;
    localparam int PH_W = TERM_W - TERM_SPLIT + WEIGHT_W + 1;
    localparam int WP_W = PH_W + TERM_SPLIT;

    t_weight                r_w2 [MAX_SLOTS];
    t_weight                r_w3 [MAX_SLOTS];
    t_weight                r_w4 [MAX_SLOTS];
    logic        [PL_W-1:0] r_pl [MAX_SLOTS][NUM_ROWS];
    logic signed [PH_W-1:0] r_ph [MAX_SLOTS][NUM_ROWS];
    logic signed [WP_W-1:0] r_wp [MAX_SLOTS][NUM_ROWS];
    logic signed [ACC_W-1:0] r_acc [NUM_ROWS];
    logic signed [ACC_W-1:0] n_acc [NUM_ROWS];
    t_word                  r_out [NUM_ROWS];
    t_word                  n_out [NUM_ROWS];

    // weight delay line to line up with the terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w2 <= i_weight;
            r_w3 <= r_w2;
            r_w4 <= r_w3;
        end
    end

    // split multiply: low half unsigned, high half signed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    r_pl[k][r] <= PL_W'(i_term[k][r][TERM_SPLIT-1:0]) * PL_W'(r_w4[k]);
                    r_ph[k][r] <= $signed(i_term[k][r][TERM_W-1:TERM_SPLIT])
                                * $signed({1'b0, r_w4[k]});
                end
            end
        end
    end

    // recombine the halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    r_wp[k][r] <= (WP_W'(r_ph[k][r]) <<< TERM_SPLIT)
                                + $signed(WP_W'(r_pl[k][r]));
                end
            end
        end
    end

    // sum over bones
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            n_acc[r] = '0;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                n_acc[r] = n_acc[r] + ACC_W'(r_wp[k][r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    // floor by the weight fraction, saturate to a word
    always_comb begin
        logic signed [ACC_W-1:0] sh;
        logic                    ovf;
        for (int r = 0; r < NUM_ROWS; r++) begin
            sh  = r_acc[r] >>> WEIGHT_FRAC;
            ovf = !((&sh[ACC_W-1:WORD_W-1]) || !(|sh[ACC_W-1:WORD_W-1]));
            if (ovf) begin
                n_out[r] = sh[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                       : {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                n_out[r] = sh[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_pos = r_out;

endmodule

// File: sv/vertex_skinning_blend_core.sv
// ----------------------------------------------------------------------------
// vertex_skinning_blend_core
// Linear blend skinning of vertex positions with up to three bones per
// vertex, one beat per cycle.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_ready  i_action .. i_weight_c
//   output   out        o_valid / i_ready  o_out_x, o_out_y, o_out_z
//
// A skin beat passes 8 register stages, the first loaded at the accepting
// edge: bank read, products, pair sums, row sum and saturate, weight
// multiply, weight recombine, bone sum, output saturate. Its output beat is
// valid from the output saturate register and is taken when i_ready is high.
// A new beat is taken every cycle unless an output stall freezes every stage.
// A load beat with a valid bone and slot writes the bone store in the cycle
// it is accepted and gives no output beat. Reset clears the stage valid bits
// only; the bone store is undefined until written.
// ----------------------------------------------------------------------------
module vertex_skinning_blend_core #(
    parameter int NUM_BONES        = 64,
    parameter int BONES_PER_VERTEX = 3,
    parameter int FRAC_BITS        = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [vsb_pkg::SLOT_W-1:0] i_element_slot,
    input  vsb_pkg::t_word             i_element_value,
    input  vsb_pkg::t_word             i_pos_x,
    input  vsb_pkg::t_word             i_pos_y,
    input  vsb_pkg::t_word             i_pos_z,
    input  vsb_pkg::t_bone             i_bone_a,
    input  vsb_pkg::t_bone             i_bone_b,
    input  vsb_pkg::t_bone             i_bone_c,
    input  vsb_pkg::t_weight           i_weight_a,
    input  vsb_pkg::t_weight           i_weight_b,
    input  vsb_pkg::t_weight           i_weight_c,
    output logic                       o_valid,
    input  logic                       i_ready,
    output vsb_pkg::t_word             o_out_x,
    output vsb_pkg::t_word             o_out_y,
    output vsb_pkg::t_word             o_out_z
);
    import vsb_pkg::*;

    localparam int NUM_SLOTS = (BONES_PER_VERTEX < MAX_SLOTS) ? BONES_PER_VERTEX
                                                              : MAX_SLOTS;
    localparam int BONE_AW   = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

    logic                    w_en;
    logic                    w_acc;
    logic                    w_skin;
    logic                    w_wr_en;
    logic [PIPE_DEPTH-1:0]   r_vld;
    t_bone                   w_bone   [MAX_SLOTS];
    t_weight                 w_weight [MAX_SLOTS];
    logic [BONE_AW-1:0]      w_rd_addr [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]    r_use;
    t_word                   r_pos    [NUM_ROWS];
    t_weight                 r_weight [MAX_SLOTS];
    t_word                   w_elem   [MAX_SLOTS][ELEMS_PER_BONE];
    t_term                   w_term   [MAX_SLOTS][NUM_ROWS];
    t_word                   w_out    [NUM_ROWS];

    function automatic logic bone_ok(input t_bone b);
        return !b[BONE_W-1] && (int'(b[BONE_W-2:0]) < NUM_BONES);
    endfunction

    // global stage enable: the whole pipe moves unless the output is held
    assign w_en    = !r_vld[PIPE_DEPTH-1] || i_ready;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;
    assign w_skin  = (t_action'(i_action) == ACT_SKIN);
    assign w_wr_en = w_acc && !w_skin && bone_ok(i_bone_a)
                   && (i_element_slot < SLOT_W'(ELEMS_PER_BONE));

    assign w_bone   = '{i_bone_a, i_bone_b, i_bone_c};
    assign w_weight = '{i_weight_a, i_weight_b, i_weight_c};

    // bank read addresses, one per bone slot
    always_comb begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
            w_rd_addr[k] = BONE_AW'(w_bone[k][BONE_W-2:0]);
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_acc && w_skin};
        end
    end

    // first stage payload alongside the bank read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos    <= '{i_pos_x, i_pos_y, i_pos_z};
            r_weight <= w_weight;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_use[k] <= w_skin && bone_ok(w_bone[k]) && (k < NUM_SLOTS);
            end
        end
    end

    vsb_bone_store #(
        .NUM_BONES (NUM_BONES),
        .NUM_SLOTS (NUM_SLOTS),
        .BONE_AW   (BONE_AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (BONE_AW'(i_bone_a[BONE_W-2:0])),
        .i_wr_slot (i_element_slot),
        .i_wr_data (i_element_value),
        .i_rd_addr (w_rd_addr),
        .o_elem    (w_elem)
    );

    // one row transform per bone slot
    for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_xform
        vsb_row_xform #(
            .FRAC_BITS (FRAC_BITS)
        ) u_xform (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_use  (r_use[k]),
            .i_elem (w_elem[k]),
            .i_pos  (r_pos),
            .o_term (w_term[k])
        );
    end

    vsb_blend u_blend (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_weight (r_weight),
        .i_term   (w_term),
        .o_pos    (w_out)
    );

    assign o_valid = r_vld[PIPE_DEPTH-1];
    assign o_out_x = w_out[0];
    assign o_out_y = w_out[1];
    assign o_out_z = w_out[2];

endmodule

// File: sv/vsb_checker.sv
// ----------------------------------------------------------------------------
// vsb_checker
// Port-level checks of the skinning core, bound to the top level.
// ----------------------------------------------------------------------------
module vsb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       i_action,
    input logic [vsb_pkg::SLOT_W-1:0] i_element_slot,
    input vsb_pkg::t_word             i_element_value,
    input vsb_pkg::t_word             i_pos_x,
    input vsb_pkg::t_word             i_pos_y,
    input vsb_pkg::t_word             i_pos_z,
    input vsb_pkg::t_bone             i_bone_a,
    input vsb_pkg::t_bone             i_bone_b,
    input vsb_pkg::t_bone             i_bone_c,
    input vsb_pkg::t_weight           i_weight_a,
    input vsb_pkg::t_weight           i_weight_b,
    input vsb_pkg::t_weight           i_weight_c,
    input logic                       o_valid,
    input logic                       i_ready,
    input vsb_pkg::t_word             o_out_x,
    input vsb_pkg::t_word             o_out_y,
    input vsb_pkg::t_word             o_out_z
);
    import vsb_pkg::*;

    // reset empties the pipe
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a held output beat keeps its payload
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x)
                                && $stable(o_out_y) && $stable(o_out_z))
        else $error("output beat changed while stalled");

    // input is only back-pressured by a held output beat
    a_ready_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without an output stall");

    // a skin beat reaches the output after the pipeline depth when not stalled
    a_skin_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (t_action'(i_action) == ACT_SKIN)
         ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
         ##1 i_ready ##1 i_ready ##1 i_ready) |=> o_valid)
        else $error("skin beat did not reach the output");

endmodule

bind vertex_skinning_blend_core vsb_checker u_vsb_checker (.*);
